>>> hw/rtl/lecm_pkg.sv
// Shared types, constants and command tables for the line-edit command matcher.
// No dependencies; every other file but lecm_line_mem refers to it by scoped names.
package lecm_pkg;

    localparam logic [1:0] KIND_ECHO    = 2'd0;
    localparam logic [1:0] KIND_LED     = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    localparam logic [7:0] CH_BS       = 8'd8;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_SP       = 8'd32;
    localparam logic [7:0] CH_DEL      = 8'd127;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd126;

    localparam logic [7:0] LEVEL_FULL = 8'd255;

    typedef enum logic [2:0] {
        WORD_WHITE = 3'd0,
        WORD_BLACK = 3'd1,
        WORD_RED   = 3'd2,
        WORD_GREEN = 3'd3,
        WORD_BLUE  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic hit;
        t_cmd cmd;
    } t_cmd_sel;

    typedef struct packed {
        logic start;
        t_cmd cmd;
    } t_match_ctl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_match_sts;

    // Command words are left-aligned in 7 bytes; position 0 is the first character.
    function automatic logic [55:0] cmd_word(input t_cmd cmd);
        logic [55:0] w;
        case (cmd)
            WORD_WHITE: w = {"LED_ON", 8'h00};
            WORD_BLACK: w = "LED_OFF";
            WORD_RED:   w = {"RED", 32'h0};
            WORD_GREEN: w = {"GREEN", 16'h0};
            WORD_BLUE:  w = {"BLUE", 24'h0};
            default:    w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] cmd_char(input t_cmd cmd, input logic [2:0] pos);
        logic [55:0] w;
        w = cmd_word(cmd);
        return w[8 * (6 - int'(pos)) +: 8];
    endfunction

    function automatic logic [2:0] cmd_len(input t_cmd cmd);
        logic [2:0] n;
        case (cmd)
            WORD_WHITE: n = 3'd6;
            WORD_BLACK: n = 3'd7;
            WORD_RED:   n = 3'd3;
            WORD_GREEN: n = 3'd5;
            WORD_BLUE:  n = 3'd4;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

    // Every command has a distinct length, so the length picks the only candidate.
    function automatic t_cmd_sel cmd_for_len(input logic [7:0] len);
        t_cmd_sel s;
        s.hit = 1'b1;
        case (len)
            8'd6:    s.cmd = WORD_WHITE;
            8'd7:    s.cmd = WORD_BLACK;
            8'd3:    s.cmd = WORD_RED;
            8'd5:    s.cmd = WORD_GREEN;
            8'd4:    s.cmd = WORD_BLUE;
            default: begin
                s.hit = 1'b0;
                s.cmd = WORD_WHITE;
            end
        endcase
        return s;
    endfunction

    // Color as {red, green, blue}.
    function automatic logic [23:0] cmd_rgb(input t_cmd cmd);
        logic [23:0] c;
        case (cmd)
            WORD_WHITE: c = {LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
            WORD_BLACK: c = 24'h0;
            WORD_RED:   c = {LEVEL_FULL, 16'h0};
            WORD_GREEN: c = {8'h0, LEVEL_FULL, 8'h0};
            WORD_BLUE:  c = {16'h0, LEVEL_FULL};
            default:    c = 24'h0;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/lecm_line_mem.sv
// Line character store: one write port, one read port with registered read data.
// No dependencies; contents are undefined until written.
module lecm_line_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lecm_matcher.sv
// Character-serial compare unit: walks the line store and checks each byte
// against one command word. Depends on lecm_pkg.
module lecm_matcher #(
    parameter int AW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lecm_pkg::t_match_ctl i_ctl,
    output lecm_pkg::t_match_sts o_sts,
    output logic [AW-1:0]        o_raddr,
    input  logic [7:0]           i_rdata
);

    logic          r_issue;
    logic          r_cmp_vld;
    logic          r_done;
    logic          r_ok;
    logic [2:0]    r_idx;
    logic [2:0]    r_cmp_pos;
    lecm_pkg::t_cmd r_cmd;
    logic [2:0]    last_pos;
    logic          mismatch;

    assign last_pos = lecm_pkg::cmd_len(r_cmd) - 3'd1;
    assign mismatch = i_rdata != lecm_pkg::cmd_char(r_cmd, r_cmp_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_cmp_vld <= r_issue;
            r_done    <= r_cmp_vld && !r_issue && (r_cmp_pos == last_pos);
            if (i_ctl.start) begin
                r_issue <= 1'b1;
            end else if (r_issue && r_idx == last_pos) begin
                r_issue <= 1'b0;
            end
        end
    end

    // Issue one address per cycle; compare each byte read back in the cycle after its address.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_idx <= 3'd0;
            r_cmd <= i_ctl.cmd;
            r_ok  <= 1'b1;
        end else begin
            if (r_issue) begin
                r_cmp_pos <= r_idx;
                r_idx     <= r_idx + 3'd1;
            end
            if (r_cmp_vld && mismatch) begin
                r_ok <= 1'b0;
            end
        end
    end

    assign o_raddr    = AW'(r_idx);
    assign o_sts.done = r_done;
    assign o_sts.hit  = r_ok;

endmodule

>>> hw/rtl/line_edit_command_matcher_unit.sv
// Line-edit command matcher: edits a console line and decodes LED color commands.
// Each accepted byte is handled in full before the next is taken (o_ready only in idle):
// a flush or ignored byte emits nothing, a printable byte is echoed, a backspace emits
// BS, SP, BS, and a line end emits CR, LF, verdict, after a serial compare (one line-store
// byte per cycle) when its length fits a command. Output stalls hold the sequence.
// Reset (i_rst_n low, synchronous) empties the line and drops any pending result.
module line_edit_command_matcher_unit #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_operation,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_tx_byte,
    output logic [7:0] o_red_level,
    output logic [7:0] o_green_level,
    output logic [7:0] o_blue_level,
    output logic       o_last
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_CAPACITY - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        MODE_CHAR = 2'd0,
        MODE_BKSP = 2'd1,
        MODE_LINE = 2'd2
    } t_mode;

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [1:0]         r_step, n_step;
    logic [7:0]         r_tx_char, n_tx_char;
    lecm_pkg::t_cmd     r_cmd, n_cmd;
    logic               r_hit, n_hit;

    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_kind, n_kind;
    logic [7:0]         r_tx, n_tx;
    logic [23:0]        r_rgb, n_rgb;
    logic               r_last, n_last;

    logic               accept;
    logic               out_free;
    logic               is_eol, is_bs, is_print;
    logic               mem_we;
    logic [LEN_W-1:0]   mem_raddr;
    logic [7:0]         mem_rdata;
    lecm_pkg::t_cmd_sel sel;
    lecm_pkg::t_match_ctl match_ctl;
    lecm_pkg::t_match_sts match_sts;

    assign o_ready  = r_state == ST_IDLE;
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign is_eol   = (i_rx_byte == lecm_pkg::CH_CR) || (i_rx_byte == lecm_pkg::CH_LF);
    assign is_bs    = (i_rx_byte == lecm_pkg::CH_BS) || (i_rx_byte == lecm_pkg::CH_DEL);
    assign is_print = (i_rx_byte >= lecm_pkg::CH_PRINT_LO)
                   && (i_rx_byte <= lecm_pkg::CH_PRINT_HI);

    // Store a printable byte at the tail while the line has room.
    assign mem_we = accept && !i_operation && is_print && (r_len != LEN_FULL);
    assign sel    = lecm_pkg::cmd_for_len(8'(r_len));

    lecm_line_mem #(
        .DEPTH (LINE_CAPACITY),
        .AW    (LEN_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_len),
        .i_wdata (i_rx_byte),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lecm_matcher #(
        .AW (LEN_W)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (match_ctl),
        .o_sts   (match_sts),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_len       = r_len;
        n_step      = r_step;
        n_tx_char   = r_tx_char;
        n_cmd       = r_cmd;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !i_ready;
        n_kind      = r_kind;
        n_tx        = r_tx;
        n_rgb       = r_rgb;
        n_last      = r_last;
        match_ctl.start = 1'b0;
        match_ctl.cmd   = sel.cmd;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_step = 2'd0;
                    if (i_operation) begin
                        // Overflow flush: drop the line, no transaction out.
                        n_len = '0;
                    end else if (is_eol) begin
                        if (r_len != '0) begin
                            n_len  = '0;
                            n_mode = MODE_LINE;
                            n_cmd  = sel.cmd;
                            n_hit  = 1'b0;
                            if (sel.hit) begin
                                // Length fits one command: compare its characters.
                                match_ctl.start = 1'b1;
                                n_state = ST_MATCH;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end
                    end else if (is_bs) begin
                        if (r_len != '0) begin
                            n_len   = r_len - LEN_W'(1);
                            n_mode  = MODE_BKSP;
                            n_state = ST_EMIT;
                        end
                    end else if (is_print) begin
                        if (r_len != LEN_FULL) begin
                            n_len     = r_len + LEN_W'(1);
                            n_tx_char = i_rx_byte;
                            n_mode    = MODE_CHAR;
                            n_state   = ST_EMIT;
                        end
                    end
                end
            end
            ST_MATCH: begin
                if (match_sts.done) begin
                    n_hit   = match_sts.hit;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = lecm_pkg::KIND_ECHO;
                    n_tx        = 8'h00;
                    n_rgb       = 24'h0;
                    n_last      = 1'b0;
                    n_step      = r_step + 2'd1;
                    case (r_mode)
                        MODE_CHAR: begin
                            n_tx   = r_tx_char;
                            n_last = 1'b1;
                        end
                        MODE_BKSP: begin
                            n_tx   = (r_step == 2'd1) ? lecm_pkg::CH_SP : lecm_pkg::CH_BS;
                            n_last = r_step == 2'd2;
                        end
                        MODE_LINE: begin
                            if (r_step == 2'd0) begin
                                n_tx = lecm_pkg::CH_CR;
                            end else if (r_step == 2'd1) begin
                                n_tx = lecm_pkg::CH_LF;
                            end else if (r_hit) begin
                                n_kind = lecm_pkg::KIND_LED;
                                n_rgb  = lecm_pkg::cmd_rgb(r_cmd);
                                n_last = 1'b1;
                            end else begin
                                n_kind = lecm_pkg::KIND_UNKNOWN;
                                n_last = 1'b1;
                            end
                        end
                        default: begin
                            n_last = 1'b1;
                        end
                    endcase
                    // Return to idle once the final transaction is loaded.
                    if (n_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_step    <= n_step;
        r_tx_char <= n_tx_char;
        r_cmd     <= n_cmd;
        r_hit     <= n_hit;
        r_kind    <= n_kind;
        r_tx      <= n_tx;
        r_rgb     <= n_rgb;
        r_last    <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx;
    assign o_red_level   = r_rgb[23:16];
    assign o_green_level = r_rgb[15:8];
    assign o_blue_level  = r_rgb[7:0];
    assign o_last        = r_last;

endmodule

>>> hw/rtl/lecm_checker.sv
// Port-level checks for the line-edit command matcher, attached by bind.
// Depends on lecm_pkg and line_edit_command_matcher_unit.
module lecm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_tx_byte,
    input logic [7:0] o_red_level,
    input logic [7:0] o_green_level,
    input logic [7:0] o_blue_level,
    input logic       o_last
);

    // Hold a stalled result transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_tx_byte)
            && $stable(o_last))
        else $error("result changed while stalled");

    // Drop any result on reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // LED and unknown verdicts always close the line-end sequence.
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != lecm_pkg::KIND_ECHO |-> o_last)
        else $error("verdict not marked last");

    // Echo transactions carry no color.
    a_echo_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == lecm_pkg::KIND_ECHO |->
            o_red_level == 8'h00 && o_green_level == 8'h00 && o_blue_level == 8'h00)
        else $error("echo with color levels");

endmodule

bind line_edit_command_matcher_unit lecm_checker u_lecm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_kind        (o_kind),
    .o_tx_byte     (o_tx_byte),
    .o_red_level   (o_red_level),
    .o_green_level (o_green_level),
    .o_blue_level  (o_blue_level),
    .o_last        (o_last)
);

>>> tb/line_edit_command_matcher_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for line_edit_command_matcher_unit: line editing, echo and commands.
// Depends on lecm_pkg and the line_edit_command_matcher_unit RTL; reads no files.
module line_edit_command_matcher_unit_test;

    localparam int LINE_CAPACITY  = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;

    // One result as seen on the output channel.
    typedef struct {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_console_result;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       i_operation   = 1'b0;
    logic [7:0] i_rx_byte     = 8'h00;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_tx_byte;
    logic [7:0] o_red_level;
    logic [7:0] o_green_level;
    logic [7:0] o_blue_level;
    logic       o_last;

    // Command words and the {red, green, blue} color that each one selects.
    string      command_words [5] = '{"LED_ON", "LED_OFF", "RED", "GREEN", "BLUE"};
    logic [23:0] command_colors [5] = '{
        {lecm_pkg::LEVEL_FULL, lecm_pkg::LEVEL_FULL, lecm_pkg::LEVEL_FULL},
        24'h000000,
        {lecm_pkg::LEVEL_FULL, 16'h0000},
        {8'h00, lecm_pkg::LEVEL_FULL, 8'h00},
        {16'h0000, lecm_pkg::LEVEL_FULL}
    };

    // Predicted line contents and the results still owed by the block.
    logic [7:0]      typed_chars [0:LINE_CAPACITY-1];
    int              typed_count = 0;
    t_console_result owed_results [$];

    bit idle_on          = 1'b1;
    int mismatch_count   = 0;
    int items_accepted   = 0;
    int results_seen     = 0;
    int leds_predicted   = 0;
    int unknown_predicted = 0;
    int stall_left       = 0;
    int quiet_cycles     = 0;

    line_edit_command_matcher_unit #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_last        (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------
    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] tx,
                                         input logic [23:0] rgb, input logic last);
        t_console_result r;
        r.kind    = kind;
        r.tx_byte = tx;
        r.red     = rgb[23:16];
        r.green   = rgb[15:8];
        r.blue    = rgb[7:0];
        r.last    = last;
        owed_results.push_back(r);
    endfunction

    // Whole-line, case-sensitive compare; -1 when no command word matches.
    function automatic int match_command();
        int  k;
        int  j;
        int  found;
        bit  same;
        found = -1;
        for (k = 0; k < 5; k++) begin
            if (command_words[k].len() == typed_count) begin
                same = 1'b1;
                for (j = 0; j < typed_count; j++) begin
                    if (typed_chars[j] != command_words[k][j]) same = 1'b0;
                end
                if (same) found = k;
            end
        end
        return found;
    endfunction

    // Advance the line state by one accepted transaction and queue what it owes.
    function automatic void predict_console_item(input logic op, input logic [7:0] rx);
        int hit;
        if (op) begin
            typed_count = 0;
        end else if (rx == lecm_pkg::CH_CR || rx == lecm_pkg::CH_LF) begin
            // Line end only acts on a non-empty line.
            if (typed_count != 0) begin
                queue_result(lecm_pkg::KIND_ECHO, lecm_pkg::CH_CR, 24'h0, 1'b0);
                queue_result(lecm_pkg::KIND_ECHO, lecm_pkg::CH_LF, 24'h0, 1'b0);
                hit = match_command();
                if (hit >= 0) begin
                    queue_result(lecm_pkg::KIND_LED, 8'h00, command_colors[hit], 1'b1);
                    leds_predicted++;
                end else begin
                    queue_result(lecm_pkg::KIND_UNKNOWN, 8'h00, 24'h0, 1'b1);
                    unknown_predicted++;
                end
                typed_count = 0;
            end
        end else if (rx == lecm_pkg::CH_BS || rx == lecm_pkg::CH_DEL) begin
            // Erase on screen with backspace, space, backspace.
            if (typed_count != 0) begin
                typed_count--;
                queue_result(lecm_pkg::KIND_ECHO, lecm_pkg::CH_BS, 24'h0, 1'b0);
                queue_result(lecm_pkg::KIND_ECHO, lecm_pkg::CH_SP, 24'h0, 1'b0);
                queue_result(lecm_pkg::KIND_ECHO, lecm_pkg::CH_BS, 24'h0, 1'b1);
            end
        end else if (rx >= lecm_pkg::CH_PRINT_LO && rx <= lecm_pkg::CH_PRINT_HI) begin
            // A full line drops the character without echo.
            if (typed_count < LINE_CAPACITY - 1) begin
                typed_chars[typed_count] = rx;
                typed_count++;
                queue_result(lecm_pkg::KIND_ECHO, rx, 24'h0, 1'b1);
            end
        end
    endfunction

    //------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------
    // Drive one transaction at the falling edge, hold it until accepted. Valid is left
    // high on return; the next send or drain decides what it does at the next falling edge.
    task automatic send_item(input logic op, input logic [7:0] rx);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_rx_byte   <= rx;
        do @(posedge i_clk); while (!o_ready);
        items_accepted++;
        predict_console_item(op, rx);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_printable();
        return 8'($urandom_range(lecm_pkg::CH_PRINT_LO, lecm_pkg::CH_PRINT_HI));
    endfunction

    function automatic logic [7:0] random_line_end();
        return $urandom_range(0, 1) ? lecm_pkg::CH_CR : lecm_pkg::CH_LF;
    endfunction

    //------------------------------------------------------------------
    // Output side: random stall bursts, then compare against the oldest owed result
    //------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result %0d: %s got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_console_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                report_mismatch("result with nothing owed, kind", o_kind, -1);
            end else begin
                want = owed_results.pop_front();
                if (o_kind !== want.kind) report_mismatch("kind", o_kind, want.kind);
                if (o_tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", o_tx_byte, want.tx_byte);
                if (o_red_level !== want.red) report_mismatch("red_level", o_red_level, want.red);
                if (o_green_level !== want.green)
                    report_mismatch("green_level", o_green_level, want.green);
                if (o_blue_level !== want.blue)
                    report_mismatch("blue_level", o_blue_level, want.blue);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

    // Count cycles with no transaction on either side; give up when the block stalls.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("line_edit_command_matcher_unit verification failed");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // Every command word, ended by CR and by LF.
    task automatic test_commands();
        send_text("LED_ON");
        send_item(1'b0, lecm_pkg::CH_CR);
        send_text("LED_OFF");
        send_item(1'b0, lecm_pkg::CH_LF);
        send_text("RED");
        send_item(1'b0, lecm_pkg::CH_CR);
        send_text("GREEN");
        send_item(1'b0, lecm_pkg::CH_LF);
        send_text("BLUE");
        send_item(1'b0, lecm_pkg::CH_CR);
        drain_results();
    endtask

    // Empty-line controls, ignored bytes, printable extremes, erase and flush.
    task automatic test_edge_bytes();
        send_item(1'b0, lecm_pkg::CH_BS);
        send_item(1'b0, lecm_pkg::CH_DEL);
        send_item(1'b0, lecm_pkg::CH_CR);
        send_item(1'b0, lecm_pkg::CH_LF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h80);
        send_item(1'b0, 8'h1F);
        send_item(1'b0, lecm_pkg::CH_PRINT_LO);
        send_item(1'b0, lecm_pkg::CH_PRINT_HI);
        send_item(1'b0, lecm_pkg::CH_DEL);
        send_item(1'b0, lecm_pkg::CH_BS);
        send_item(1'b0, lecm_pkg::CH_LF);
        send_text("rEd");
        send_item(1'b1, 8'hFF);
        send_item(1'b0, lecm_pkg::CH_CR);
        send_item(1'b1, 8'h00);
        drain_results();
    endtask

    // Fill the line to capacity, overflow it, erase and refill the last slot.
    task automatic test_line_full();
        int i;
        for (i = 0; i < LINE_CAPACITY - 1; i++) send_item(1'b0, random_printable());
        send_item(1'b0, random_printable());
        send_item(1'b0, lecm_pkg::CH_BS);
        send_item(1'b0, random_printable());
        send_item(1'b0, random_printable());
        send_item(1'b0, lecm_pkg::CH_CR);
        drain_results();
    endtask

    // One random sequence: mostly command lines with small damage, some noise.
    task automatic send_random_sequence();
        logic [7:0] chars [$];
        int         pick;
        int         word;
        int         pos;
        int         edit_at;
        int         i;
        int         n;
        pick = $urandom_range(0, 19);
        chars.delete();
        if (pick < 15) begin
            if (pick < 12) begin
                word = $urandom_range(0, 4);
                for (i = 0; i < command_words[word].len(); i++)
                    chars.push_back(command_words[word][i]);
                pos = $urandom_range(0, chars.size() - 1);
                case ($urandom_range(0, 6))
                    1: chars[pos] = random_printable();
                    2: chars.pop_back();
                    3: chars.push_back(chars[0]);
                    4: begin
                        if (chars[pos] >= 8'h41 && chars[pos] <= 8'h5A)
                            chars[pos] = chars[pos] | 8'h20;
                    end
                    default: ;
                endcase
            end else begin
                n = $urandom_range(1, 12);
                for (i = 0; i < n; i++) chars.push_back(random_printable());
            end
            // Sometimes mistype a character and erase it before going on.
            edit_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, chars.size()) : -1;
            for (i = 0; i <= chars.size(); i++) begin
                if (i == edit_at) begin
                    send_item(1'b0, random_printable());
                    send_item(1'b0, $urandom_range(0, 1) ? lecm_pkg::CH_BS : lecm_pkg::CH_DEL);
                end
                if (i < chars.size()) send_item(1'b0, chars[i]);
            end
            send_item(1'b0, random_line_end());
            if ($urandom_range(0, 7) == 0) send_item(1'b0, random_line_end());
        end else if (pick < 17) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) send_item(1'b0, 8'($urandom_range(0, 255)));
        end else if (pick == 17) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) send_item(1'b0, random_printable());
            send_item(1'b1, 8'($urandom_range(0, 255)));
        end else if (pick == 18) begin
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++) send_item(1'b0, random_printable());
            for (i = 0; i < n + 2; i++)
                send_item(1'b0, $urandom_range(0, 1) ? lecm_pkg::CH_BS : lecm_pkg::CH_DEL);
        end else begin
            send_item(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic(input int item_count);
        int stop_at;
        stop_at = items_accepted + item_count;
        while (items_accepted < stop_at) send_random_sequence();
        drain_results();
    endtask

    // Same traffic with both sides always ready.
    task automatic test_back_to_back(input int item_count);
        idle_on = 1'b0;
        test_random_traffic(item_count);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        typed_count = 0;

        test_commands();
        test_edge_bytes();
        test_line_full();
        test_random_traffic(20);
        test_back_to_back(15);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d console bytes and flushes, checked %0d results.",
                 items_accepted, results_seen);
        $display("Lines ended: %0d LED commands, %0d unknown.",
                 leds_predicted, unknown_predicted);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("line_edit_command_matcher_unit verification clean");
        end else begin
            $display("%0d mismatches, %0d results never seen",
                     mismatch_count, owed_results.size());
            $display("line_edit_command_matcher_unit verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lecm_pkg.sv
hw/rtl/lecm_line_mem.sv
hw/rtl/lecm_matcher.sv
hw/rtl/line_edit_command_matcher_unit.sv
hw/rtl/lecm_checker.sv
tb/line_edit_command_matcher_unit_test.sv
